// ===== sv/gql_pkg.sv =====
// ----------------------------------------------------------------------------
// gql_pkg
// Shared types and constants for the glyph quad layout block.
// ----------------------------------------------------------------------------
package gql_pkg;

    localparam int VERTEX_CAPACITY_DEF = 4096;

    localparam logic [31:0] FIX_ONE      = 32'h0001_0000;
    localparam logic [7:0]  NEWLINE_CODE = 8'd10;

    localparam logic OP_START = 1'b0;
    localparam logic OP_CHAR  = 1'b1;

    // register map, byte address = 4 * index
    localparam int          ADDR_W          = 5;
    localparam logic [2:0]  REG_SCREEN_W    = 3'd0;
    localparam logic [2:0]  REG_SCREEN_H    = 3'd1;
    localparam logic [2:0]  REG_GLYPH_W     = 3'd2;
    localparam logic [2:0]  REG_GLYPH_H     = 3'd3;
    localparam logic [2:0]  REG_GLYPH_GAP   = 3'd4;

    localparam logic [12:0] SCREEN_W_RST  = 13'd320;
    localparam logic [12:0] SCREEN_H_RST  = 13'd240;
    localparam logic [22:0] GLYPH_W_RST   = 23'd524288;
    localparam logic [22:0] GLYPH_H_RST   = 23'd524288;
    localparam logic [22:0] GLYPH_GAP_RST = 23'd65536;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 176;
    localparam int M_TUSER_W = 2;

    // derived layout constants, handed from the register file to the core
    typedef struct packed {
        logic [31:0]        right_off;   // glyph_width - 1.0
        logic [31:0]        bottom_off;  // glyph_height - 1.0
        logic [31:0]        x_step;      // glyph_width + gap
        logic [31:0]        y_step;      // glyph_height + gap
        logic signed [31:0] max_x;       // (W - 1) * 1.0
        logic signed [31:0] max_y;       // (H - 1) * 1.0
    } layout_cfg_t;

    typedef struct packed {
        logic               visible;
        logic               overflow;
        logic [11:0]        vertex_base;
        logic [12:0]        index_base;
        logic [10:0]        material_base;
        logic [7:0]         glyph;
        logic signed [31:0] left_x;
        logic signed [31:0] top_y;
        logic signed [31:0] right_x;
        logic signed [31:0] bottom_y;
    } quad_result_t;

endpackage

// ===== sv/gql_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// gql_cfg_regs
// APB register file; precomputes the offsets and bounds used by the core.
// ----------------------------------------------------------------------------
module gql_cfg_regs import gql_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output layout_cfg_t       cfg
);

    logic [12:0] screen_w_reg;
    logic [12:0] screen_h_reg;
    logic [22:0] glyph_w_reg;
    logic [22:0] glyph_h_reg;
    logic [22:0] glyph_gap_reg;
    layout_cfg_t cfg_reg;
    layout_cfg_t cfg_next;
    logic        wr_en;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_w_reg  <= SCREEN_W_RST;
            screen_h_reg  <= SCREEN_H_RST;
            glyph_w_reg   <= GLYPH_W_RST;
            glyph_h_reg   <= GLYPH_H_RST;
            glyph_gap_reg <= GLYPH_GAP_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SCREEN_W:  screen_w_reg  <= pwdata[12:0];
                REG_SCREEN_H:  screen_h_reg  <= pwdata[12:0];
                REG_GLYPH_W:   glyph_w_reg   <= pwdata[22:0];
                REG_GLYPH_H:   glyph_h_reg   <= pwdata[22:0];
                REG_GLYPH_GAP: glyph_gap_reg <= pwdata[22:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SCREEN_W:  prdata = {19'd0, screen_w_reg};
            REG_SCREEN_H:  prdata = {19'd0, screen_h_reg};
            REG_GLYPH_W:   prdata = {9'd0, glyph_w_reg};
            REG_GLYPH_H:   prdata = {9'd0, glyph_h_reg};
            REG_GLYPH_GAP: prdata = {9'd0, glyph_gap_reg};
            default:       prdata = 32'd0;
        endcase
    end

    always_comb begin
        cfg_next.right_off  = {9'd0, glyph_w_reg} - FIX_ONE;
        cfg_next.bottom_off = {9'd0, glyph_h_reg} - FIX_ONE;
        cfg_next.x_step     = {9'd0, glyph_w_reg} + {9'd0, glyph_gap_reg};
        cfg_next.y_step     = {9'd0, glyph_h_reg} + {9'd0, glyph_gap_reg};
        cfg_next.max_x      = $signed({3'd0, screen_w_reg, 16'd0} - FIX_ONE);
        cfg_next.max_y      = $signed({3'd0, screen_h_reg, 16'd0} - FIX_ONE);
    end

    // writes must come only while idle (the block itself does not enforce it), so the registered cfg lag is never seen
    always_ff @(posedge aclk) begin
        cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/gql_core.sv =====
// ----------------------------------------------------------------------------
// gql_core
// Input register, cursor and counter state, quad placement and culling,
// result register.
// ----------------------------------------------------------------------------
module gql_core import gql_pkg::*; #(
    parameter int VERTEX_CAPACITY = VERTEX_CAPACITY_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  layout_cfg_t        cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               in_op,
    input  logic signed [31:0] in_origin_x,
    input  logic signed [31:0] in_origin_y,
    input  logic [7:0]         in_char_code,
    output logic               out_valid,
    input  logic               out_ready,
    output quad_result_t       out_result
);

    localparam int VC_W = $clog2(VERTEX_CAPACITY + 1);
    localparam logic [VC_W-1:0] VC_LIMIT = VC_W'(VERTEX_CAPACITY - 4);
    localparam logic [VC_W-1:0] VC_STEP  = VC_W'(4);

    // input stage
    logic        in_valid_reg;
    logic        op_reg;
    logic [31:0] origin_x_reg;
    logic [31:0] origin_y_reg;
    logic [7:0]  code_reg;

    // layout state
    logic [31:0]     cursor_x_reg;
    logic [31:0]     cursor_y_reg;
    logic [31:0]     line_start_x_reg;
    logic [VC_W-1:0] vertex_count_reg;
    logic [12:0]     index_count_reg;
    logic [10:0]     material_count_reg;

    // result stage
    logic         out_valid_reg;
    quad_result_t result_reg;
    quad_result_t result_next;

    logic        is_char;
    logic        is_newline;
    logic        has_result;
    logic        out_free;
    logic        advance;
    logic        full;
    logic        vis;
    logic [31:0] right;
    logic [31:0] bottom;
    logic [31:0] vc_wide;

    assign is_char    = (op_reg == OP_CHAR);
    assign is_newline = is_char && (code_reg == NEWLINE_CODE);
    assign has_result = is_char && !is_newline;
    assign out_free   = !out_valid_reg || out_ready;
    assign advance    = in_valid_reg && (!has_result || out_free);
    assign in_ready   = !in_valid_reg || advance;

    assign full   = (vertex_count_reg > VC_LIMIT);
    assign right  = cursor_x_reg + cfg.right_off;
    assign bottom = cursor_y_reg + cfg.bottom_off;
    assign vc_wide = 32'(vertex_count_reg);

    // x and y ranges are separable, so the four corners reduce to two spans
    assign vis = !cursor_x_reg[31] && ($signed(cursor_x_reg) <= cfg.max_x)
              && !right[31]        && ($signed(right)        <= cfg.max_x)
              && !cursor_y_reg[31] && ($signed(cursor_y_reg) <= cfg.max_y)
              && !bottom[31]       && ($signed(bottom)       <= cfg.max_y);

    always_comb begin
        result_next          = '0;
        result_next.glyph    = code_reg;
        if (full) begin
            result_next.overflow = 1'b1;
        end else begin
            result_next.vertex_base = vc_wide[11:0];
            result_next.left_x      = $signed(cursor_x_reg);
            result_next.top_y       = $signed(cursor_y_reg);
            result_next.right_x     = $signed(right);
            result_next.bottom_y    = $signed(bottom);
            if (vis) begin
                result_next.visible       = 1'b1;
                result_next.index_base    = index_count_reg;
                result_next.material_base = material_count_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            op_reg       <= in_op;
            origin_x_reg <= in_origin_x;
            origin_y_reg <= in_origin_y;
            code_reg     <= in_char_code;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_x_reg       <= '0;
            cursor_y_reg       <= '0;
            line_start_x_reg   <= '0;
            vertex_count_reg   <= '0;
            index_count_reg    <= '0;
            material_count_reg <= '0;
        end else if (advance) begin
            if (!is_char) begin
                line_start_x_reg <= origin_x_reg;
                cursor_x_reg     <= origin_x_reg;
                cursor_y_reg     <= origin_y_reg;
            end else if (is_newline) begin
                cursor_x_reg <= line_start_x_reg;
                cursor_y_reg <= cursor_y_reg + cfg.y_step;
            end else if (!full) begin
                cursor_x_reg     <= cursor_x_reg + cfg.x_step;
                vertex_count_reg <= vertex_count_reg + VC_STEP;
                if (vis) begin
                    index_count_reg    <= index_count_reg + 13'd6;
                    material_count_reg <= material_count_reg + 11'd2;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && has_result) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && has_result) begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

endmodule

// ===== sv/glyph_quad_layout.sv =====
// ----------------------------------------------------------------------------
// glyph_quad_layout
// Lays out one 16.16 screen quad per non-newline character of a bitmap-font text stream.
// ----------------------------------------------------------------------------
// Takes one transfer per cycle while the output is not stalled. A character is
// held in an input register and then in a result register, from which its
// result is presented on the master stream; the cursor and slot counters
// update in the same cycle the result register loads, so back-to-back
// characters see each other's cursor. Start items and newlines give no output
// transfer. Output stalls back up through the input register only when a
// result is pending; once VERTEX_CAPACITY slots are used every further
// non-newline character returns an overflow result until reset.
module glyph_quad_layout import gql_pkg::*; #(
    parameter int VERTEX_CAPACITY = VERTEX_CAPACITY_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // slave stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // origin_x[31:0], origin_y[63:32], char_code[71:64]
    input  logic                 s_tuser,  // op
    // master stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // vertex_base[11:0], index_base[24:12],
                                           // material_base[35:25], glyph[43:36],
                                           // left_x[75:44], top_y[107:76],
                                           // right_x[139:108], bottom_y[171:140], zero
    output logic [M_TUSER_W-1:0] m_tuser,  // visible[0], overflow[1]
    // APB
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    layout_cfg_t  cfg;
    quad_result_t result;

    gql_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gql_core #(
        .VERTEX_CAPACITY (VERTEX_CAPACITY)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_op        (s_tuser),
        .in_origin_x  ($signed(s_tdata[31:0])),
        .in_origin_y  ($signed(s_tdata[63:32])),
        .in_char_code (s_tdata[71:64]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_result   (result)
    );

    assign m_tuser = {result.overflow, result.visible};
    assign m_tdata = {4'd0,
                      result.bottom_y,
                      result.right_x,
                      result.top_y,
                      result.left_x,
                      result.glyph,
                      result.material_base,
                      result.index_base,
                      result.vertex_base};

endmodule

// ===== sv/gql_checker.sv =====
// ----------------------------------------------------------------------------
// gql_checker
// Port-level checks on the glyph quad layout result stream.
// ----------------------------------------------------------------------------
module gql_checker import gql_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_overflow_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |->
            !m_tuser[0] && m_tdata[35:0] == 36'd0 && m_tdata[M_TDATA_W-1:44] == '0)
        else $error("overflow result carries quad data");

    a_culled_bases: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[35:12] == 24'd0)
        else $error("culled quad carries index or material base");

    a_visible_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[1:0] == 2'd0 && m_tdata[12] == 1'b0
            && m_tdata[25] == 1'b0)
        else $error("visible quad bases misaligned");

endmodule

bind glyph_quad_layout gql_checker u_gql_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== sim/glyph_quad_layout_chk.sv =====
// ----------------------------------------------------------------------------
// glyph_quad_layout_chk
// Monitors the register, input and result ports of glyph_quad_layout.
// The register port is watched to keep a local copy of the layout settings.
// The input stream drives an independent model of the cursor and the slot
// counters. Each quad result is compared field by field against the oldest
// queued prediction.
// ----------------------------------------------------------------------------
module glyph_quad_layout_chk import gql_pkg::*; #(
    parameter int VERTEX_CAPACITY = VERTEX_CAPACITY_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [M_TUSER_W-1:0] m_tuser,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [31:0]          pwdata,
    input  logic                 pready,
    output int                   mismatches,
    output int                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [12:0]  scr_w, scr_h;
    logic [22:0]  glyph_w, glyph_h, glyph_gap;
    logic [31:0]  cur_x, cur_y, line_x;
    int unsigned  vtx_used;
    logic [12:0]  idx_used;
    logic [11:0]  mat_used;
    quad_result_t quad_q[$];

    function automatic bit on_screen(logic [31:0] x, logic [31:0] y);
        longint lim_x = longint'(scr_w) * 65536 - 65536;
        longint lim_y = longint'(scr_h) * 65536 - 65536;
        longint sx = longint'($signed(x));
        longint sy = longint'($signed(y));
        return sx >= 0 && sy >= 0 && sx <= lim_x && sy <= lim_y;
    endfunction

    function automatic quad_result_t place_quad(logic [7:0] code);
        quad_result_t q;
        logic [31:0]  rx, by;
        bit           vis;
        q = '0;
        q.glyph = code;
        if (vtx_used + 4 > VERTEX_CAPACITY) begin
            q.overflow = 1'b1;
            return q;
        end
        rx  = cur_x + glyph_w - FIX_ONE;
        by  = cur_y + glyph_h - FIX_ONE;
        vis = on_screen(cur_x, cur_y) && on_screen(cur_x, by) &&
              on_screen(rx, cur_y) && on_screen(rx, by);
        q.vertex_base = vtx_used[11:0];
        q.left_x      = cur_x;
        q.top_y       = cur_y;
        q.right_x     = rx;
        q.bottom_y    = by;
        vtx_used += 4;
        if (vis) begin
            q.visible       = 1'b1;
            q.index_base    = idx_used;
            q.material_base = mat_used[10:0];
            idx_used = idx_used + 13'd6;
            mat_used = mat_used + 12'd2;
        end
        cur_x = cur_x + glyph_w + glyph_gap;
        return q;
    endfunction

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        quad_result_t want, got;
        if (!aresetn) begin
            scr_w      = SCREEN_W_RST;
            scr_h      = SCREEN_H_RST;
            glyph_w    = GLYPH_W_RST;
            glyph_h    = GLYPH_H_RST;
            glyph_gap  = GLYPH_GAP_RST;
            cur_x      = '0;
            cur_y      = '0;
            line_x     = '0;
            vtx_used   = 0;
            idx_used   = '0;
            mat_used   = '0;
            mismatches = 0;
            quad_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_SCREEN_W:  scr_w     = pwdata[12:0];
                    REG_SCREEN_H:  scr_h     = pwdata[12:0];
                    REG_GLYPH_W:   glyph_w   = pwdata[22:0];
                    REG_GLYPH_H:   glyph_h   = pwdata[22:0];
                    REG_GLYPH_GAP: glyph_gap = pwdata[22:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got               = '0;
                got.visible       = m_tuser[0];
                got.overflow      = m_tuser[1];
                got.vertex_base   = m_tdata[11:0];
                got.index_base    = m_tdata[24:12];
                got.material_base = m_tdata[35:25];
                got.glyph         = m_tdata[43:36];
                got.left_x        = m_tdata[75:44];
                got.top_y         = m_tdata[107:76];
                got.right_x       = m_tdata[139:108];
                got.bottom_y      = m_tdata[171:140];
                if (quad_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    mismatches++;
                end else begin
                    want = quad_q.pop_front();
                    compare_field("visible", want.visible, got.visible);
                    compare_field("overflow", want.overflow, got.overflow);
                    compare_field("vertex_base", want.vertex_base, got.vertex_base);
                    compare_field("index_base", want.index_base, got.index_base);
                    compare_field("material_base", want.material_base, got.material_base);
                    compare_field("glyph", want.glyph, got.glyph);
                    compare_field("left_x", want.left_x, got.left_x);
                    compare_field("top_y", want.top_y, got.top_y);
                    compare_field("right_x", want.right_x, got.right_x);
                    compare_field("bottom_y", want.bottom_y, got.bottom_y);
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == OP_START) begin
                    line_x = s_tdata[31:0];
                    cur_x  = line_x;
                    cur_y  = s_tdata[63:32];
                end else if (s_tdata[71:64] == NEWLINE_CODE) begin
                    cur_y = cur_y + glyph_h + glyph_gap;
                    cur_x = line_x;
                end else begin
                    quad_q.push_back(place_quad(s_tdata[71:64]));
                end
            end
        end
        outstanding = quad_q.size();
    end

endmodule

// ===== sim/glyph_quad_layout_tb.sv =====
// ----------------------------------------------------------------------------
// glyph_quad_layout_tb
// Stimulus and verdict for the glyph quad layout block.
// A directed string covers edge-inclusive culling, coordinate wrap and the
// newline neighbors. Random strings then run under several screen and glyph
// settings, including zero, minimum, maximum and out-of-range values. The
// last phase fills the vertex store so that later characters overflow.
// The input side sends in random bursts and the output side stalls in
// changing patterns.
// ----------------------------------------------------------------------------
module glyph_quad_layout_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gql_pkg::*;

    localparam int         STALL_LIMIT  = 4000;
    localparam int         DRAIN_CYCLES = 8;
    localparam logic [2:0] REG_SPARE    = 3'd5;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid, s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // origin_x[31:0], origin_y[63:32], char_code[71:64]
    logic                 s_tuser;   // op
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;   // vertex_base, index_base, material_base, glyph,
                                     // left_x, top_y, right_x, bottom_y
    logic [M_TUSER_W-1:0] m_tuser;   // visible[0], overflow[1]
    logic                 psel, penable, pwrite, pready;
    logic [ADDR_W-1:0]    paddr;
    logic [31:0]          pwdata, prdata;

    int          pending, fails;
    int          burst_left, quads_sent, quiet;
    int unsigned cur_w, cur_h;
    int          rx_mode, rx_left, rx_tick;

    glyph_quad_layout uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    glyph_quad_layout_chk chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .mismatches(fails), .outstanding(pending)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // output-side stall patterns
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 200);
        end else begin
            rx_left = rx_left - 1;
        end
        rx_tick = rx_tick + 1;
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 7) == 0);
            default: m_tready <= ((rx_tick % 7) < 4);
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable && pready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_item(logic op, logic [31:0] ox, logic [31:0] oy, logic [7:0] code);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 100)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {code, oy, ox};
        if (op == OP_CHAR && code != NEWLINE_CODE)
            quads_sent++;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_start(logic [31:0] ox, logic [31:0] oy);
        send_item(OP_START, ox, oy, 8'($urandom));
    endtask

    task automatic send_char(logic [7:0] code);
        send_item(OP_CHAR, $urandom, $urandom, code);
    endtask

    function automatic logic [31:0] pick_origin(int unsigned span);
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 32'h7FF0_0000 | $urandom_range(0, 32'h000F_FFFF);
            2: return -$urandom_range(0, 32'h0004_0000);
            default: return ($urandom_range(0, span) << 16) |
                            (($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : 0);
        endcase
    endfunction

    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            send_start(pick_origin(cur_w), pick_origin(cur_h));
        else if (r < 12)
            send_char(NEWLINE_CODE);
        else
            send_char(8'($urandom));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    // upper bits above each register's width are filled with junk when asked
    task automatic apply_layout(int unsigned w, int unsigned h, int unsigned gw,
                                int unsigned gh, int unsigned gap, bit junk);
        logic [31:0] pad;
        pad = junk ? $urandom : 32'd0;
        write_reg(REG_SCREEN_W, (pad << 13) | w);
        write_reg(REG_SCREEN_H, (pad << 13) | h);
        write_reg(REG_GLYPH_W, (pad << 23) | gw);
        write_reg(REG_GLYPH_H, (pad << 23) | gh);
        write_reg(REG_GLYPH_GAP, (pad << 23) | gap);
        cur_w = w & 32'h1FFF;
        cur_h = h & 32'h1FFF;
    endtask

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = OP_START;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        burst_left = 0;
        quads_sent = 0;
        quiet      = 0;
        rx_mode    = 0;
        rx_left    = 0;
        rx_tick    = 0;
        cur_w      = SCREEN_W_RST;
        cur_h      = SCREEN_H_RST;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed string on reset settings
        send_start(32'h0000_0000, 32'h0000_0000);
        send_char(8'd65);
        send_char(8'd0);
        send_char(8'd255);
        send_char(NEWLINE_CODE);
        send_char(8'd9);
        send_char(8'd11);
        send_start(32'h0138_0000, 32'h00E8_0000);   // bottom-right corner on the edge
        send_char(8'd66);
        send_char(8'd67);
        send_start(32'hFFFF_FFFF, 32'h0000_0000);
        send_char(8'd68);
        send_start(32'h0000_0000, 32'h00E8_0001);
        send_char(8'd69);
        send_start(32'h7FFF_0000, 32'h7FFF_8000);   // corners wrap negative
        send_char(8'd70);
        send_char(8'd71);
        send_start(32'h8000_0000, 32'h8000_0000);
        send_char(8'd72);
        send_start(32'h0000_0000, 32'h7FFF_FFFF);
        send_char(NEWLINE_CODE);
        send_char(8'd73);

        for (int ph = 0; ph < 7; ph++) begin
            wait_idle();
            case (ph)
                0: apply_layout(640, 480, 524288, 1048576, 65536, 1'b0);
                1: apply_layout(4096, 4096, 4194304, 4194304, 4194304, 1'b0);
                2: apply_layout(1, 1, 65536, 65536, 0, 1'b0);
                3: apply_layout(0, 0, $urandom_range(65536, 4194304),
                                $urandom_range(65536, 4194304),
                                $urandom_range(0, 4194304), 1'b0);
                4: apply_layout(8191, 8191, 23'h7F_FFFF, 23'h7F_FFFF, 23'h7F_FFFF, 1'b1);
                5: begin
                    apply_layout(320, 200, 0, 0, 0, 1'b1);
                    write_reg(REG_SPARE, $urandom);
                end
                default: apply_layout($urandom_range(1, 4096), $urandom_range(1, 4096),
                                      $urandom_range(65536, 4194304),
                                      $urandom_range(65536, 4194304),
                                      $urandom_range(0, 4194304),
                                      1'($urandom_range(0, 1)));
            endcase
            repeat (120) random_item();
        end

        // fill the vertex store, then keep going into overflow
        wait_idle();
        apply_layout($urandom_range(64, 1024), $urandom_range(64, 1024),
                     $urandom_range(65536, 1048576), $urandom_range(65536, 1048576),
                     $urandom_range(0, 131072), 1'b0);
        while (quads_sent < VERTEX_CAPACITY_DEF / 4 + 48)
            random_item();

        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== glyph_quad_layout.f =====
sv/gql_pkg.sv
sv/gql_cfg_regs.sv
sv/gql_core.sv
sv/glyph_quad_layout.sv
sv/gql_checker.sv
sim/glyph_quad_layout_chk.sv
sim/glyph_quad_layout_tb.sv
